// ----- sv/plec_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package plec_pkg;

    typedef enum logic [1:0] {
        MODE_BINARY   = 2'd0,
        MODE_TEXT     = 2'd1,
        MODE_MIME     = 2'd2,
        MODE_CLEARSIG = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        DEST_FILE   = 2'd0,
        DEST_DIGEST = 2'd1,
        DEST_ERROR  = 2'd2
    } t_dest;

    // clearsig line-ending tracker
    typedef enum logic [1:0] {
        LS_IDLE = 2'd0,
        LS_CR   = 2'd1,
        LS_EOL  = 2'd2
    } t_line;

    typedef logic [1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_MODE          = 2'd0;
    localparam t_cfg_idx CFG_OUTPUT_ENABLE = 2'd1;
    localparam t_cfg_idx CFG_HASH_ENABLE   = 2'd2;
    localparam t_cfg_idx CFG_OUT_LIMIT     = 2'd3;

    localparam int CFG_DATA_W = 32;

    localparam logic [7:0] CH_CR = 8'h0d;
    localparam logic [7:0] CH_LF = 8'h0a;

    typedef logic [2:0] t_res_cnt;

    typedef struct packed {
        t_dest      dest;
        logic [7:0] data;
    } t_result;

    typedef struct packed {
        t_mode       mode;
        logic        output_enable;
        logic        hash_enable;
        logic [31:0] out_limit;
    } t_cfg;

    typedef struct packed {
        t_line       line_state;
        logic [31:0] written_count;
        logic        aborted;
    } t_state;

    typedef struct packed {
        t_result [3:0] res;
        t_res_cnt      cnt;
        t_state        nxt;
    } t_step;

endpackage

`default_nettype wire

// ----- sv/plec_step.sv -----
`timescale 1ns / 1ps
`default_nettype none

module plec_step import plec_pkg::*; (
    input  wire logic [7:0] i_byte,
    input  wire logic       i_start,
    input  wire t_cfg       i_cfg,
    input  wire t_state     i_state,
    output t_step           o_step
);

    t_line       ls0;
    t_line       cur;
    logic        ab0;
    logic        file_on;
    logic        count_on;
    logic [32:0] cnt_next;
    logic        err;
    t_res_cnt    k;

    always_comb begin
        ls0 = i_start ? LS_IDLE : i_state.line_state;
        ab0 = i_start ? 1'b0 : i_state.aborted;

        // file side: text mode drops cr
        if (i_cfg.mode == MODE_CLEARSIG) begin
            file_on = i_cfg.output_enable;
        end else begin
            file_on = i_cfg.output_enable && !(i_cfg.mode == MODE_TEXT && i_byte == CH_CR);
        end
        count_on = file_on && (i_cfg.out_limit != 32'd0);
        cnt_next = {1'b0, i_state.written_count} + 33'd1;
        err      = count_on && (cnt_next > {1'b0, i_cfg.out_limit});

        o_step                   = '0;
        o_step.nxt.line_state    = ls0;
        o_step.nxt.written_count = i_state.written_count;
        o_step.nxt.aborted       = ab0;
        cur                      = ls0;
        k                        = '0;

        if (!ab0) begin
            if (count_on) begin
                o_step.nxt.written_count = cnt_next[32] ? '1 : cnt_next[31:0];
            end
            o_step.nxt.aborted = err;

            if (i_cfg.mode == MODE_CLEARSIG) begin
                if (file_on) begin
                    o_step.res[k[1:0]] = err ? t_result'{dest: DEST_ERROR, data: 8'd0}
                                             : t_result'{dest: DEST_FILE, data: i_byte};
                    k = k + 3'd1;
                end
                if (!err && i_cfg.hash_enable) begin
                    // flush a held line ending first
                    if (ls0 == LS_EOL) begin
                        o_step.res[k[1:0]] = '{dest: DEST_DIGEST, data: CH_CR};
                        k = k + 3'd1;
                        o_step.res[k[1:0]] = '{dest: DEST_DIGEST, data: CH_LF};
                        k = k + 3'd1;
                        cur = LS_IDLE;
                    end
                    if (cur == LS_CR) begin
                        if (i_byte == CH_LF) begin
                            o_step.nxt.line_state = LS_EOL;
                        end else begin
                            o_step.res[k[1:0]] = '{dest: DEST_DIGEST, data: CH_CR};
                            k = k + 3'd1;
                            if (i_byte == CH_CR) begin
                                o_step.nxt.line_state = LS_CR;
                            end else begin
                                o_step.nxt.line_state = LS_IDLE;
                                o_step.res[k[1:0]] = '{dest: DEST_DIGEST, data: i_byte};
                                k = k + 3'd1;
                            end
                        end
                    end else begin
                        if (i_byte == CH_CR) begin
                            o_step.nxt.line_state = LS_CR;
                        end else if (i_byte == CH_LF) begin
                            o_step.nxt.line_state = LS_EOL;
                        end else begin
                            o_step.nxt.line_state = LS_IDLE;
                            o_step.res[k[1:0]] = '{dest: DEST_DIGEST, data: i_byte};
                            k = k + 3'd1;
                        end
                    end
                end
            end else begin
                if (i_cfg.hash_enable) begin
                    o_step.res[k[1:0]] = '{dest: DEST_DIGEST, data: i_byte};
                    k = k + 3'd1;
                end
                if (file_on) begin
                    o_step.res[k[1:0]] = err ? t_result'{dest: DEST_ERROR, data: 8'd0}
                                             : t_result'{dest: DEST_FILE, data: i_byte};
                    k = k + 3'd1;
                end
            end
        end
        o_step.cnt = k;
    end

endmodule

`default_nettype wire

// ----- sv/plec_outq.sv -----
`timescale 1ns / 1ps
`default_nettype none

module plec_outq import plec_pkg::*; (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_load,
    input  wire t_result [3:0] i_res,
    input  wire t_res_cnt      i_cnt,
    input  wire logic          i_pop,
    output t_result            o_head,
    output logic               o_valid,
    output logic               o_last,
    output logic               o_free
);

    t_result [3:0] r_ent;
    t_result [3:0] n_ent;
    t_res_cnt      r_cnt;
    t_res_cnt      n_cnt;
    logic          take;

    assign o_valid = (r_cnt != '0);
    assign o_last  = (r_cnt == 3'd1);
    assign o_head  = r_ent[0];
    assign take    = o_valid && i_pop;
    // free when empty or the last entry leaves this cycle
    assign o_free  = !o_valid || (o_last && i_pop);

    always_comb begin
        n_ent = r_ent;
        n_cnt = r_cnt;
        if (i_load) begin
            n_ent = i_res;
            n_cnt = i_cnt;
        end else if (take) begin
            for (int i = 0; i < 3; i++) begin
                n_ent[i] = r_ent[i + 1];
            end
            n_cnt = r_cnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

// ----- sv/plaintext_line_ending_splitter_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Splits literal-data payload bytes into file and digest requests. Each byte
// request on the slave side makes zero to four result requests on the master
// side: digest bytes (tuser 1), file bytes (tuser 0) or a limit error
// (tuser 2), with tlast on the final one of each byte. Results leave one per
// cycle while m_axis_tready is high, from a four-entry result register; the
// next byte is taken in the cycle its predecessor's last result is taken.
// The user must write configuration through i_cfg_we/i_cfg_idx/i_cfg_data
// only while idle (the block itself does not enforce this), at these indices:
// 0 mode, 1 output enable, 2 hash enable, 3 max output (0 = no limit).

module plaintext_line_ending_splitter_unit import plec_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // config write port
    input  wire logic                  i_cfg_we,
    input  wire t_cfg_idx              i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    // byte request in
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [7:0]            s_axis_tdata,  // [7:0] data_byte
    input  wire logic                  s_axis_tuser,  // [0] packet_start
    // result request out
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [7:0]                 m_axis_tdata,  // [7:0] out_byte
    output logic [1:0]                 m_axis_tuser,  // [1:0] dest
    output logic                       m_axis_tlast   // last_of_run
);

    t_cfg    r_cfg;
    t_state  r_state;
    t_step   step;
    t_result head;
    logic    in_acc;
    logic    q_free;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode          <= MODE_BINARY;
            r_cfg.output_enable <= 1'b1;
            r_cfg.hash_enable   <= 1'b1;
            r_cfg.out_limit     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MODE:          r_cfg.mode          <= t_mode'(i_cfg_data[1:0]);
                CFG_OUTPUT_ENABLE: r_cfg.output_enable <= i_cfg_data[0];
                CFG_HASH_ENABLE:   r_cfg.hash_enable   <= i_cfg_data[0];
                CFG_OUT_LIMIT:     r_cfg.out_limit     <= i_cfg_data[31:0];
            endcase
        end
    end

    // per-byte decision logic, results land in the queue register
    plec_step u_step (
        .i_byte  (s_axis_tdata),
        .i_start (s_axis_tuser),
        .i_cfg   (r_cfg),
        .i_state (r_state),
        .o_step  (step)
    );

    assign s_axis_tready = q_free;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // line tracker, file byte counter and abort flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.line_state    <= LS_IDLE;
            r_state.written_count <= '0;
            r_state.aborted       <= 1'b0;
        end else if (in_acc) begin
            r_state <= step.nxt;
        end
    end

    plec_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (in_acc),
        .i_res   (step.res),
        .i_cnt   (step.cnt),
        .i_pop   (m_axis_tready),
        .o_head  (head),
        .o_valid (m_axis_tvalid),
        .o_last  (m_axis_tlast),
        .o_free  (q_free)
    );

    assign m_axis_tdata = head.data;
    assign m_axis_tuser = head.dest;

    // a new byte only enters when no earlier result would be lost
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> (!m_axis_tvalid || (m_axis_tlast && m_axis_tready)))
        else $error("byte accepted over pending results");

    // an error result carries a zero byte and ends its run
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == DEST_ERROR) |->
            (m_axis_tdata == 8'd0 && m_axis_tlast))
        else $error("malformed limit error result");

    // aborted packet bytes make no result
    a_abort_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_state.aborted && !s_axis_tuser) |=> !m_axis_tvalid)
        else $error("result from aborted packet");

    // file byte counter never goes back
    a_count_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_state.written_count >= $past(r_state.written_count)))
        else $error("written count decreased");

endmodule

`default_nettype wire
